[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// plain invariant, checked at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

`endif

[hw/rtl/rdsm_pkg.sv]
// ----------------------------------------------------------------------------
// rdsm_pkg
// shared codes, constants and control types of the dot-star regex matcher
// ----------------------------------------------------------------------------
package rdsm_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // pattern metacharacters
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    // default element capacity
    localparam int MAX_ELEMENTS_DEF = 32;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted word
        logic closure;   // register the star closure of the active set
        logic apply;     // execute the latched operation
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_query;  // latched operation produces a result word
    } t_status;

endpackage

[hw/rtl/rdsm_ctrl.sv]
// ----------------------------------------------------------------------------
// rdsm_ctrl
// sequencer for capture, closure and apply, plus the output valid flag
// ----------------------------------------------------------------------------
module rdsm_ctrl
    import rdsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_CLOSURE = 2'd1;
    localparam logic [1:0] S_APPLY   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_blocked;

    // a query must wait while the result register still holds an untaken word
    assign w_out_blocked = i_status.is_query && r_out_valid && !i_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CLOSURE;
                end
            end
            S_CLOSURE: begin
                o_cmd.closure = 1'b1;
                n_state       = S_APPLY;
            end
            S_APPLY: begin
                if (!w_out_blocked) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_cmd.apply && i_status.is_query) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[hw/rtl/rdsm_datapath.sv]
// ----------------------------------------------------------------------------
// rdsm_datapath
// pattern element cells, nfa active set, closure adder and result register
// ----------------------------------------------------------------------------
module rdsm_datapath
    import rdsm_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [1:0] i_op,
    input  logic [7:0] i_byte_value,
    output t_status    o_status,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    localparam int N  = MAX_ELEMENTS;
    localparam int CW = $clog2(N + 1);

    // element cells, no reset: entries at or above the count are masked off
    logic [7:0]    r_chars [N];
    logic [N-1:0]  r_starred;

    logic [CW-1:0] r_count;
    logic          r_pending;
    logic          r_overflow;
    logic [N:0]    r_active;

    logic [1:0]    r_op;
    logic [7:0]    r_byte;
    logic [N:0]    r_cur;
    logic          r_matched;
    logic          r_ovf_out;

    logic [N-1:0]  w_mask;
    logic [N-1:0]  w_prop;
    logic [N-1:0]  w_gen;
    logic [N:0]    w_sum;
    logic [N:0]    w_carry;
    logic [N:0]    w_closure;
    logic [N-1:0]  w_hit;
    logic [N:0]    w_next;
    logic [N:0]    w_restart;
    logic          w_star_apply;
    logic          w_full;
    logic          w_append;

    // live elements are those below the count
    always_comb begin
        for (int p = 0; p < N; p++) begin
            w_mask[p] = (r_count > CW'(p));
        end
    end

    // star closure as a carry chain: a starred element propagates, an active starred one generates
    assign w_prop    = r_starred & w_mask;
    assign w_gen     = r_active[N-1:0] & w_prop;
    assign w_sum     = {1'b0, w_prop} + {1'b0, w_gen};
    assign w_carry   = w_sum ^ {1'b0, w_prop} ^ {1'b0, w_gen};
    assign w_closure = r_active | w_carry;

    // one compare cell per element on the closed set
    always_comb begin
        for (int p = 0; p < N; p++) begin
            w_hit[p] = w_mask[p] && r_cur[p]
                       && ((r_chars[p] == DOT_BYTE) || (r_chars[p] == r_byte));
        end
    end

    // starred hit stays, plain hit advances
    assign w_next    = {1'b0, w_hit & r_starred} | {w_hit & ~r_starred, 1'b0};
    assign w_restart = {{N{1'b0}}, 1'b1};

    // append decode
    assign w_append     = i_cmd.apply && (r_op == OP_APPEND);
    assign w_star_apply = (r_byte == STAR_BYTE) && r_pending && (r_count != '0);
    assign w_full       = (r_count == CW'(N));

    // word latch, closure register and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_byte <= i_byte_value;
        end
        if (i_cmd.closure) begin
            r_cur <= w_closure;
        end
        if (i_cmd.apply && (r_op == OP_QUERY)) begin
            r_matched <= !r_overflow && r_cur[r_count];
            r_ovf_out <= r_overflow;
        end
    end

    // element cell writes
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < N; p++) begin
            if (w_append && !w_star_apply && !w_full && (r_count == CW'(p))) begin
                r_chars[p]   <= r_byte;
                r_starred[p] <= 1'b0;
            end
            if (w_append && w_star_apply && (r_count == CW'(p + 1))) begin
                r_starred[p] <= 1'b1;
            end
        end
    end

    // pattern bookkeeping and active set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_pending  <= 1'b0;
            r_overflow <= 1'b0;
            r_active   <= w_restart;
        end else if (i_cmd.apply) begin
            case (r_op)
                OP_CLEAR: begin
                    r_count    <= '0;
                    r_pending  <= 1'b0;
                    r_overflow <= 1'b0;
                    r_active   <= w_restart;
                end
                OP_APPEND: begin
                    r_active <= w_restart;
                    if (w_star_apply) begin
                        r_pending <= 1'b0;
                    end else if (w_full) begin
                        r_overflow <= 1'b1;
                        r_pending  <= 1'b0;
                    end else begin
                        r_count   <= r_count + 1'b1;
                        r_pending <= 1'b1;
                    end
                end
                OP_TEXT: begin
                    r_active <= w_next;
                end
                OP_QUERY: begin
                    r_active <= w_restart;
                end
                default: begin
                    r_active <= w_restart;
                end
            endcase
        end
    end

    assign o_status.is_query = (r_op == OP_QUERY);
    assign o_matched         = r_matched;
    assign o_pattern_overflow = r_ovf_out;

endmodule

[hw/rtl/regex_dot_star_matcher_unit.sv]
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_unit
// whole-string matcher for byte patterns with '.' and '*'
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready) carries one word: i_op and i_byte_value.
//   op clear empties the pattern, op append adds a pattern byte, op text feeds
//   one text byte through the nfa, op query returns one output word
//   (o_matched, o_pattern_overflow) on the o_valid / i_ready channel and then
//   restarts the text. append also discards any partial text.
//   every word passes capture, star closure (one adder carry chain across
//   all elements), then apply in the element compare cells. o_ready is
//   high again in the cycle after apply, so a new word is taken only once
//   the last one is applied. a query result is registered in its apply step.
//   the result register frees the input side: new words are taken while a
//   result waits. only a second query stalls in its apply step until the
//   receiver takes the pending result.
//   after reset the pattern is empty, no overflow, text at the start, no
//   result pending. queries answer 0 after the pattern overflowed until
//   a clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module regex_dot_star_matcher_unit
    import rdsm_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    rdsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // element cells and nfa state
    rdsm_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_op               (i_op),
        .i_byte_value       (i_byte_value),
        .o_status           (w_status),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    // checks
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "ready high right after an accepted word")
    `ASSERT_CLK(a_valid_from_query, i_clk, i_rst_n, $rose(o_valid) |-> $past(w_cmd.apply && w_status.is_query), "result word without a query apply")
    `ASSERT_ALWAYS(a_ovf_no_match, i_clk, i_rst_n, !(o_valid && o_matched && o_pattern_overflow), "match reported with pattern overflow")

endmodule

[tb/sv/regex_dot_star_matcher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_unit_tb
// self-checking bench for the dot-star regex matcher
// ----------------------------------------------------------------------------
// words go in on the valid/ready input channel and query answers come back on
// the output channel. a scoreboard keeps its own element list and nfa reach
// vector, predicts the answer to every query and checks the answers in order.
// a short directed run covers the corner cases. random pattern, text and query
// sequences follow, with noise words mixed in. the sender pauses and the
// receiver stalls at random.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher_unit_tb;
    import rdsm_pkg::*;

    localparam int MAX_EL       = MAX_ELEMENTS_DEF;
    localparam int N_RANDOM     = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // pattern store, reach vector and queue of predicted query answers
    class match_scoreboard;
        logic [7:0]  elem_byte [MAX_EL];
        bit          elem_star [MAX_EL];
        int          elem_cnt;
        bit          star_open;
        bit [MAX_EL:0] reach;
        bit          ovf;
        t_verdict    verdict_q[$];
        int          n_words;
        int          n_answers;
        int          n_hits;
        int          n_ovf;
        int          n_err;

        function new();
            clear_all();
            n_words   = 0;
            n_answers = 0;
            n_hits    = 0;
            n_ovf     = 0;
            n_err     = 0;
        endfunction

        function void clear_all();
            elem_cnt  = 0;
            star_open = 1'b0;
            ovf       = 1'b0;
            reach     = 1;
        endfunction

        // reach vector with every starred element skippable
        function bit [MAX_EL:0] closed();
            bit [MAX_EL:0] c;
            c = reach;
            for (int p = 0; p < elem_cnt; p++)
                if (c[p] && elem_star[p]) c[p + 1] = 1'b1;
            return c;
        endfunction

        function void flag(string msg);
            n_err++;
            if (n_err <= 10) $display("%0t: %s", $time, msg);
        endfunction

        // accepted input word
        function void note_word(logic [1:0] op, logic [7:0] b);
            bit [MAX_EL:0] c;
            bit [MAX_EL:0] nxt;
            t_verdict v;
            n_words++;
            case (op)
                OP_CLEAR: clear_all();
                OP_APPEND: begin
                    reach = 1;
                    if (b == STAR_BYTE && star_open && elem_cnt > 0) begin
                        elem_star[elem_cnt - 1] = 1'b1;
                        star_open = 1'b0;
                    end else if (elem_cnt >= MAX_EL) begin
                        ovf       = 1'b1;
                        star_open = 1'b0;
                    end else begin
                        elem_byte[elem_cnt] = b;
                        elem_star[elem_cnt] = 1'b0;
                        elem_cnt++;
                        star_open = 1'b1;
                    end
                end
                OP_TEXT: begin
                    c   = closed();
                    nxt = '0;
                    for (int p = 0; p < elem_cnt; p++) begin
                        if (c[p] && (elem_byte[p] == DOT_BYTE || elem_byte[p] == b)) begin
                            if (elem_star[p]) nxt[p] = 1'b1;
                            else nxt[p + 1] = 1'b1;
                        end
                    end
                    reach = nxt;
                end
                OP_QUERY: begin
                    c          = closed();
                    v.matched  = !ovf && c[elem_cnt];
                    v.overflow = ovf;
                    verdict_q.push_back(v);
                    reach = 1;
                end
            endcase
        endfunction

        // result word taken by the receiver
        function void check_result(logic m, logic ov);
            t_verdict v;
            n_answers++;
            if (m === 1'b1) n_hits++;
            if (ov === 1'b1) n_ovf++;
            if (verdict_q.size() == 0) begin
                flag($sformatf("answer with no query pending: matched %b overflow %b", m, ov));
            end else begin
                v = verdict_q.pop_front();
                if (v.matched !== m || v.overflow !== ov)
                    flag($sformatf("answer mismatch: expected matched %b overflow %b, got %b %b",
                                   v.matched, v.overflow, m, ov));
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_op         = OP_CLEAR;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_matched;
    logic       o_pattern_overflow;

    match_scoreboard sb;
    int n_sent      = 0;
    int idle_cycles = 0;
    bit tx_quiet    = 1'b0;

    regex_dot_star_matcher_unit #(
        .MAX_ELEMENTS(MAX_EL)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_byte_value      (i_byte_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_matched         (o_matched),
        .o_pattern_overflow(o_pattern_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // text byte drawn mostly from the pattern alphabet
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'h61 + 8'($urandom_range(0, 2));
        if (r == 4) return STAR_BYTE;
        if (r == 5) return DOT_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // present one word and hold it until accepted
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_byte_value <= b;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    // input and output monitors plus watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_word(i_op, i_byte_value);
            if (o_valid && i_ready) sb.check_result(o_matched, o_pattern_overflow);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: runs of ready broken by random stalls
    initial begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (run_left > 0) begin
                i_ready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 24);
                stall_left = pick_gap(1'b0);
                i_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0] pat_ch [MAX_EL + 8];
        bit         pat_st [MAX_EL + 8];
        logic [7:0] ch;
        int         n_dir;
        int         n_elem;
        int         kind;
        int         reps;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern against empty and one-byte text
        send_word(OP_QUERY, 8'h00);
        send_word(OP_TEXT, 8'h00);
        send_word(OP_QUERY, 8'hFF);
        // leading star is a literal, the next star repeats it
        send_word(OP_APPEND, STAR_BYTE);
        send_word(OP_APPEND, STAR_BYTE);
        send_word(OP_TEXT, STAR_BYTE);
        send_word(OP_TEXT, STAR_BYTE);
        send_word(OP_QUERY, 8'h00);
        // extreme bytes, dot, starred element
        send_word(OP_CLEAR, 8'hFF);
        send_word(OP_APPEND, 8'hFF);
        send_word(OP_APPEND, DOT_BYTE);
        send_word(OP_APPEND, 8'h61);
        send_word(OP_APPEND, STAR_BYTE);
        send_word(OP_TEXT, 8'hFF);
        // pattern byte in the middle of text drops the partial text
        send_word(OP_APPEND, 8'h00);
        send_word(OP_TEXT, 8'hFF);
        send_word(OP_TEXT, 8'h55);
        send_word(OP_TEXT, 8'h61);
        send_word(OP_TEXT, 8'h61);
        send_word(OP_TEXT, 8'h00);
        send_word(OP_QUERY, 8'hAA);
        // back-to-back queries, the second one waits on the first answer
        send_word(OP_QUERY, 8'h00);
        send_word(OP_QUERY, 8'h00);
        n_dir = n_sent;

        while (n_sent < n_dir + N_RANDOM) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            kind     = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: arbitrary words
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                // pattern build, sometimes on top of the old one
                if (kind != 1) send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
                n_elem = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_EL - 4, MAX_EL + 4)
                                                     : $urandom_range(0, 6);
                for (int e = 0; e < n_elem; e++) begin
                    kind = $urandom_range(0, 9);
                    if (kind < 5) ch = 8'h61 + 8'($urandom_range(0, 2));
                    else if (kind < 7) ch = DOT_BYTE;
                    else if (kind == 7) ch = STAR_BYTE;
                    else ch = 8'($urandom_range(0, 255));
                    // a star after an unstarred element would repeat it instead
                    if (ch == STAR_BYTE && e > 0 && !pat_st[e - 1]) ch = 8'h62;
                    pat_ch[e] = ch;
                    pat_st[e] = ($urandom_range(0, 9) < 3);
                    send_word(OP_APPEND, ch);
                    if (pat_st[e]) send_word(OP_APPEND, STAR_BYTE);
                end
                // a few texts, each closed by a query
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) < 6) begin
                        for (int e = 0; e < n_elem && e < MAX_EL; e++) begin
                            reps = pat_st[e] ? $urandom_range(0, 3) : 1;
                            repeat (reps)
                                send_word(OP_TEXT, (pat_ch[e] == DOT_BYTE)
                                                   ? 8'($urandom_range(0, 255)) : pat_ch[e]);
                        end
                    end else begin
                        repeat ($urandom_range(0, 6)) send_word(OP_TEXT, pick_text_byte());
                    end
                    // now and then a pattern byte breaks into the text
                    if ($urandom_range(0, 19) == 0) send_word(OP_APPEND, pick_text_byte());
                    send_word(OP_QUERY, 8'($urandom_range(0, 255)));
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("words accepted: %0d, query answers checked: %0d (%0d matched, %0d overflowed)",
                 sb.n_words, sb.n_answers, sb.n_hits, sb.n_ovf);
        $display("answer mismatches: %0d", sb.n_err);
        if (sb.n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
